@@ rtl/sdtq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants of the sorted deadline timer queue: request
// codes, payload structs, sizes and the wrap-aware time compare.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  // sizes of the slot file and of the time base
  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CntW     = $clog2(NumSlots + 1);
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DelayW   = 31;
  localparam int unsigned ReqW     = 3;

  // query answers
  localparam logic [DelayW-1:0] IdleDelay   = DelayW'(1000);
  localparam logic [TimeW-1:0]  DelayMargin = TimeW'(5);

  // request codes
  typedef enum logic [ReqW-1:0] {
    ReqAdd      = 3'd0,
    ReqModify   = 3'd1,
    ReqDelete   = 3'd2,
    ReqDispatch = 3'd3,
    ReqQuery    = 3'd4
  } req_type_e;

  // input item
  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [SlotW-1:0] slot_id;
    logic [TimeW-1:0] deadline;
    logic [TimeW-1:0] now_ms;
  } req_t;

  // result item
  typedef struct packed {
    logic              fired;
    logic [SlotW-1:0]  fired_slot;
    logic              already_set;
    logic [DelayW-1:0] delay_ms;
    logic              last;
  } rsp_t;

  // a lies before b when the wrapped difference is negative
  function automatic logic is_before(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return diff[TimeW-1];
  endfunction

endpackage
`default_nettype wire

@@ rtl/sorted_deadline_timer_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Timer slot file with pending slots kept in ascending deadline order.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add, modify, delete and dispatch rebuild
// the ordered list by walking it through the order memory, one entry per
// cycle, from one bank into the other. A dispatch that fires slots hands
// them out one by one, each read back from the order memory and then offered
// to the consumer, instead of the single result. A modify that finds the same
// deadline, a query, a delete of an idle slot or a request that is ignored
// does not walk the list. Deadlines live in a second memory, read with the
// slot id that comes out of the order memory. The result register lets a
// result wait for the consumer while the next request is accepted.
module sorted_deadline_timer_queue import sdtq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);

  typedef enum logic [3:0] {
    StIdle, StModChk, StWalk, StWalkEnd, StResp, StQryA, StQryB, StQryC,
    StEmitRd, StEmitWt
  } state_e;

  typedef enum logic [1:0] {
    ModeInsert, ModeRemove, ModeDispatch
  } mode_e;

  // control state
  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [NumSlots-1:0] pending_q, pending_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              bank_q, bank_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   w_q, w_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [CntW-1:0]   e_q, e_d;
  logic              v1_q, v1_d;
  logic              v2_q, v2_d;
  logic              placed_q, placed_d;
  logic              out_valid_q, out_valid_d;

  // payload registers
  req_t              req_q, req_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;
  logic [SlotW-1:0]  t2_q, t2_d;
  logic [SlotW-1:0]  carry_q, carry_d;

  // order memory: two banks of the slot list
  logic [SlotW-1:0]  om_mem [2*NumSlots];
  logic              om_re, om_we;
  logic [SlotW:0]    om_raddr, om_waddr;
  logic [SlotW-1:0]  om_wdata, om_rdata_q;

  // deadline memory
  logic [TimeW-1:0]  dm_mem [NumSlots];
  logic              dm_re, dm_we;
  logic [SlotW-1:0]  dm_raddr, dm_waddr;
  logic [TimeW-1:0]  dm_wdata, dm_rdata_q;

  logic              out_free;
  logic              slot_ok;
  logic              walk_done;
  logic [TimeW-1:0]  qdiff;
  logic [SlotW-1:0]  top_idx;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign slot_ok     = ({1'b0, in_data_i.slot_id} < CntW'(NumSlots));
  assign walk_done   = (rd_idx_q == count_q) && !v1_q && !v2_q;
  assign qdiff       = dm_rdata_q - req_q.now_ms - DelayMargin;
  assign top_idx     = SlotW'(NumSlots - 1);

  // next-state and memory access logic
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pending_d   = pending_q;
    count_d     = count_q;
    bank_d      = bank_q;
    rd_idx_d    = rd_idx_q;
    w_d         = w_q;
    k_d         = k_q;
    e_d         = e_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    placed_d    = placed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    t2_d        = t2_q;
    carry_d     = carry_q;
    om_re       = 1'b0;
    om_raddr    = '0;
    om_we       = 1'b0;
    om_waddr    = '0;
    om_wdata    = '0;
    dm_re       = 1'b0;
    dm_raddr    = '0;
    dm_we       = 1'b0;
    dm_waddr    = '0;
    dm_wdata    = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d       = in_data_i;
          res_d       = '0;
          res_d.last  = 1'b1;
          rd_idx_d    = '0;
          w_d         = '0;
          k_d         = '0;
          e_d         = '0;
          placed_d    = 1'b0;
          state_d     = StResp;
          case (in_data_i.req_type)
            ReqAdd: begin
              if (slot_ok) begin
                dm_we    = 1'b1;
                dm_waddr = in_data_i.slot_id;
                dm_wdata = in_data_i.deadline;
                mode_d   = ModeInsert;
                state_d  = StWalk;
              end
            end
            ReqModify: begin
              if (slot_ok) begin
                dm_re    = 1'b1;
                dm_raddr = in_data_i.slot_id;
                state_d  = StModChk;
              end
            end
            ReqDelete: begin
              if (slot_ok && pending_q[in_data_i.slot_id]) begin
                mode_d  = ModeRemove;
                state_d = StWalk;
              end
            end
            ReqDispatch: begin
              mode_d  = ModeDispatch;
              state_d = StWalk;
            end
            ReqQuery: begin
              if (count_q == '0) begin
                res_d.delay_ms = IdleDelay;
              end else begin
                state_d = StQryA;
              end
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end

      // modify: same deadline on a pending slot leaves everything alone
      StModChk: begin
        if (pending_q[req_q.slot_id] && (dm_rdata_q == req_q.deadline)) begin
          res_d.already_set = 1'b1;
          state_d           = StResp;
        end else begin
          dm_we    = 1'b1;
          dm_waddr = req_q.slot_id;
          dm_wdata = req_q.deadline;
          mode_d   = ModeInsert;
          state_d  = StWalk;
        end
      end

      // three-stage walk: order read, deadline read, rewrite into other bank
      StWalk: begin
        if (rd_idx_q < count_q) begin
          om_re    = 1'b1;
          om_raddr = {bank_q, rd_idx_q[SlotW-1:0]};
          rd_idx_d = rd_idx_q + CntW'(1);
          v1_d     = 1'b1;
        end
        if (v1_q) begin
          dm_re    = 1'b1;
          dm_raddr = om_rdata_q;
          t2_d     = om_rdata_q;
          v2_d     = 1'b1;
        end
        if (v2_q) begin
          case (mode_q)
            ModeInsert: begin
              if (t2_q != req_q.slot_id) begin
                om_we    = 1'b1;
                om_waddr = {!bank_q, w_q[SlotW-1:0]};
                w_d      = w_q + CntW'(1);
                if (placed_q) begin
                  // one behind after the insertion point
                  om_wdata = carry_q;
                  carry_d  = t2_q;
                end else if (is_before(req_q.deadline, dm_rdata_q)) begin
                  om_wdata = req_q.slot_id;
                  carry_d  = t2_q;
                  placed_d = 1'b1;
                end else begin
                  om_wdata = t2_q;
                end
              end
            end
            ModeRemove: begin
              if (t2_q != req_q.slot_id) begin
                om_we    = 1'b1;
                om_waddr = {!bank_q, w_q[SlotW-1:0]};
                om_wdata = t2_q;
                w_d      = w_q + CntW'(1);
              end
            end
            ModeDispatch: begin
              om_we    = 1'b1;
              om_wdata = t2_q;
              if (!is_before(req_q.now_ms, dm_rdata_q)) begin
                // fired ids fill the new bank from the top down
                om_waddr        = {!bank_q, top_idx - k_q[SlotW-1:0]};
                k_d             = k_q + CntW'(1);
                pending_d[t2_q] = 1'b0;
              end else begin
                om_waddr = {!bank_q, w_q[SlotW-1:0]};
                w_d      = w_q + CntW'(1);
              end
            end
            default: begin
              om_we = 1'b0;
            end
          endcase
        end
        if (walk_done) begin
          state_d = StWalkEnd;
        end
      end

      // finish the list and switch banks
      StWalkEnd: begin
        bank_d  = !bank_q;
        state_d = StResp;
        case (mode_q)
          ModeInsert: begin
            om_we    = 1'b1;
            om_waddr = {!bank_q, w_q[SlotW-1:0]};
            om_wdata = placed_q ? carry_q : req_q.slot_id;
            count_d  = w_q + CntW'(1);
            pending_d[req_q.slot_id] = 1'b1;
          end
          ModeRemove: begin
            count_d = w_q;
            pending_d[req_q.slot_id] = 1'b0;
          end
          ModeDispatch: begin
            count_d = w_q;
            if (k_q != '0) begin
              state_d = StEmitRd;
            end
          end
          default: begin
            count_d = count_q;
          end
        endcase
      end

      // single result transfer
      StResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = StIdle;
        end
      end

      // query: head of list, then its deadline
      StQryA: begin
        om_re    = 1'b1;
        om_raddr = {bank_q, SlotW'(0)};
        state_d  = StQryB;
      end
      StQryB: begin
        dm_re    = 1'b1;
        dm_raddr = om_rdata_q;
        state_d  = StQryC;
      end
      StQryC: begin
        if (qdiff[TimeW-1] || (qdiff == '0)) begin
          res_d.delay_ms = '0;
        end else begin
          res_d.delay_ms = qdiff[DelayW-1:0];
        end
        state_d = StResp;
      end

      // fired slots, in list order
      StEmitRd: begin
        om_re    = 1'b1;
        om_raddr = {bank_q, top_idx - e_q[SlotW-1:0]};
        state_d  = StEmitWt;
      end
      StEmitWt: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.fired      = 1'b1;
          out_d.fired_slot = om_rdata_q;
          out_d.last       = ((e_q + CntW'(1)) == k_q);
          e_d              = e_q + CntW'(1);
          state_d          = out_d.last ? StIdle : StEmitRd;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= ModeInsert;
      pending_q   <= '0;
      count_q     <= '0;
      bank_q      <= 1'b0;
      rd_idx_q    <= '0;
      w_q         <= '0;
      k_q         <= '0;
      e_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      placed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pending_q   <= pending_d;
      count_q     <= count_d;
      bank_q      <= bank_d;
      rd_idx_q    <= rd_idx_d;
      w_q         <= w_d;
      k_q         <= k_d;
      e_q         <= e_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      placed_q    <= placed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    out_q   <= out_d;
    t2_q    <= t2_d;
    carry_q <= carry_d;
  end

  // order memory
  always_ff @(posedge clk_i) begin
    if (om_we) begin
      om_mem[om_waddr] <= om_wdata;
    end
    if (om_re) begin
      om_rdata_q <= om_mem[om_raddr];
    end
  end

  // deadline memory
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata_q <= dm_mem[dm_raddr];
    end
  end

endmodule
`default_nettype wire

@@ dv/sorted_deadline_timer_queue_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_test
// Self-checking bench for the sorted deadline timer queue. A behavioral copy
// of the timer list predicts every result. Directed cases cover the empty
// list, ordering, ties, re-arming, wrap-around and query limits. Random
// traffic and full-list bursts follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_test;
  import sdtq_pkg::*;

  // request codes the block ignores
  localparam logic [ReqW-1:0] ReqUnusedFirst = 3'd5;
  localparam logic [ReqW-1:0] ReqUnusedLast  = 3'd7;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned ReportLimit = 10;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  sorted_deadline_timer_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // behavioral copy of the timer list
  logic             armed        [NumSlots];
  logic [TimeW-1:0] expiry       [NumSlots];
  logic [SlotW-1:0] expiry_order [$];
  rsp_t             answer_q     [$];

  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned result_count;
  int unsigned fired_count;
  int unsigned already_count;
  int unsigned idle_cycles;
  bit          idle_en;
  logic [TimeW-1:0] clock_ms;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // wrapped difference negative means a lies before b
  function automatic logic earlier(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return diff[TimeW-1];
  endfunction

  function automatic void unlink_slot(logic [SlotW-1:0] s);
    for (int i = 0; i < expiry_order.size(); i++) begin
      if (expiry_order[i] == s) begin
        expiry_order.delete(i);
        break;
      end
    end
    armed[s] = 1'b0;
  endfunction

  // insert in front of the first later deadline, ties stay in arrival order
  function automatic void arm_slot(logic [SlotW-1:0] s, logic [TimeW-1:0] dl);
    int pos;
    if (armed[s]) unlink_slot(s);
    expiry[s] = dl;
    pos = expiry_order.size();
    for (int j = 0; j < expiry_order.size(); j++) begin
      if (earlier(dl, expiry[expiry_order[j]])) begin
        pos = j;
        break;
      end
    end
    expiry_order.insert(pos, s);
    armed[s] = 1'b1;
  endfunction

  // update the list for one request and queue the answers it causes
  function automatic void timer_answers(req_t r);
    rsp_t             ans;
    logic [SlotW-1:0] s;
    logic [SlotW-1:0] keep     [$];
    logic [SlotW-1:0] fired_ids[$];
    logic [TimeW-1:0] gap;
    ans      = '0;
    ans.last = 1'b1;
    s        = r.slot_id;
    case (r.req_type)
      ReqAdd: arm_slot(s, r.deadline);
      ReqModify: begin
        if (armed[s] && expiry[s] == r.deadline) begin
          ans.already_set = 1'b1;
          already_count++;
        end else begin
          arm_slot(s, r.deadline);
        end
      end
      ReqDelete: begin
        if (armed[s]) unlink_slot(s);
      end
      ReqDispatch: begin
        // whole list is walked, expired entries fire even behind later ones
        foreach (expiry_order[i]) begin
          if (!earlier(r.now_ms, expiry[expiry_order[i]])) begin
            fired_ids.push_back(expiry_order[i]);
            armed[expiry_order[i]] = 1'b0;
          end else begin
            keep.push_back(expiry_order[i]);
          end
        end
        expiry_order = keep;
        if (fired_ids.size() > 0) begin
          foreach (fired_ids[i]) begin
            ans            = '0;
            ans.fired      = 1'b1;
            ans.fired_slot = fired_ids[i];
            ans.last       = (i == fired_ids.size() - 1);
            answer_q.push_back(ans);
          end
          fired_count += fired_ids.size();
          return;
        end
      end
      ReqQuery: begin
        if (expiry_order.size() == 0) begin
          ans.delay_ms = IdleDelay;
        end else begin
          gap = expiry[expiry_order[0]] - r.now_ms - DelayMargin;
          if (!gap[TimeW-1] && gap != '0) ans.delay_ms = gap[DelayW-1:0];
        end
      end
      default: ;
    endcase
    answer_q.push_back(ans);
  endfunction

  function automatic req_t make_req(logic [ReqW-1:0] code, logic [SlotW-1:0] slot,
                                    logic [TimeW-1:0] dl, logic [TimeW-1:0] now);
    req_t r;
    r.req_type = code;
    r.slot_id  = slot;
    r.deadline = dl;
    r.now_ms   = now;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // one request transfer, then an optional idle gap on the request side
  task automatic send_req(req_t r);
    int unsigned gap;
    in_data_i  <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    timer_answers(r);
    sent_count++;
    gap = (idle_en && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what, rsp_t want, rsp_t got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%s: expected fired=%0b slot=%0d already=%0b delay=%0d last=%0b",
               what, want.fired, want.fired_slot, want.already_set, want.delay_ms,
               want.last);
      $display("  got fired=%0b slot=%0d already=%0b delay=%0d last=%0b",
               got.fired, got.fired_slot, got.already_set, got.delay_ms, got.last);
    end
  endtask

  // result side stalls
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  // compare each result transfer with the oldest answer
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      result_count++;
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data_o);
      end else begin
        want = answer_q.pop_front();
        if (want.fired !== out_data_o.fired || want.fired_slot !== out_data_o.fired_slot ||
            want.already_set !== out_data_o.already_set ||
            want.delay_ms !== out_data_o.delay_ms || want.last !== out_data_o.last) begin
          report_mismatch("result mismatch", want, out_data_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // empty list answers and ignored codes
  task automatic test_empty_requests();
    send_req(make_req(ReqQuery, 4'd0, $urandom, 32'd0));
    send_req(make_req(ReqDispatch, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(make_req(ReqDelete, 4'd3, $urandom, $urandom));
    send_req(make_req(ReqUnusedFirst, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(make_req(ReqUnusedLast, 4'd0, 32'd0, 32'd0));
  endtask

  // ordering, ties, re-insertion, already-set and query edges
  task automatic test_ordering();
    send_req(make_req(ReqAdd, 4'd0, 32'd100, $urandom));
    send_req(make_req(ReqAdd, 4'd15, 32'd0, $urandom));
    send_req(make_req(ReqAdd, 4'd7, 32'd100, $urandom));
    send_req(make_req(ReqAdd, 4'd8, 32'd100, $urandom));
    send_req(make_req(ReqAdd, 4'd0, 32'd50, $urandom));
    send_req(make_req(ReqModify, 4'd8, 32'd100, $urandom));
    send_req(make_req(ReqModify, 4'd15, 32'd200, $urandom));
    send_req(make_req(ReqModify, 4'd9, 32'd60, $urandom));
    send_req(make_req(ReqQuery, 4'd0, $urandom, 32'd0));
    send_req(make_req(ReqQuery, 4'd0, $urandom, 32'd45));
    send_req(make_req(ReqQuery, 4'd0, $urandom, 32'd48));
    send_req(make_req(ReqDelete, 4'd7, $urandom, $urandom));
    send_req(make_req(ReqDelete, 4'd7, $urandom, $urandom));
    send_req(make_req(ReqDispatch, 4'd0, $urandom, 32'd100));
    send_req(make_req(ReqDispatch, 4'd0, $urandom, 32'd150));
  endtask

  // wrap-around: expired entry behind unexpired ones, largest query delay
  task automatic test_wrap_dispatch();
    send_req(make_req(ReqAdd, 4'd2, 32'd0, $urandom));
    send_req(make_req(ReqAdd, 4'd3, 32'h7000_0000, $urandom));
    send_req(make_req(ReqAdd, 4'd4, 32'hE000_0000, $urandom));
    send_req(make_req(ReqDispatch, 4'd0, $urandom, 32'h9000_0000));
    send_req(make_req(ReqQuery, 4'd0, $urandom, 32'h5FFF_FFFC));
    send_req(make_req(ReqQuery, 4'd0, $urandom, 32'h5FFF_FFFB));
    send_req(make_req(ReqDispatch, 4'd0, $urandom, 32'hFFFF_FFFF));
  endtask

  // mixed traffic around a moving time base
  task automatic test_random_traffic(int unsigned count);
    int unsigned      r;
    logic [SlotW-1:0] s;
    logic [TimeW-1:0] dl;
    logic [TimeW-1:0] now;
    logic [ReqW-1:0]  code;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) idle_en = ($urandom_range(0, 3) != 0);
      r    = $urandom_range(0, 99);
      s    = SlotW'($urandom_range(0, NumSlots - 1));
      dl   = $urandom;
      now  = $urandom;
      code = ReqAdd;
      if (r < 33) begin
        if ($urandom_range(0, 9) != 0) dl = clock_ms + $urandom_range(0, 400);
      end else if (r < 48) begin
        code = ReqModify;
        dl   = clock_ms + $urandom_range(0, 400);
        if (expiry_order.size() > 0 && $urandom_range(0, 1) == 1) begin
          s  = expiry_order[$urandom_range(0, expiry_order.size() - 1)];
          dl = expiry[s];
        end
      end else if (r < 58) begin
        code = ReqDelete;
        if (expiry_order.size() > 0 && $urandom_range(0, 4) < 3)
          s = expiry_order[$urandom_range(0, expiry_order.size() - 1)];
      end else if (r < 80) begin
        code = ReqDispatch;
        if ($urandom_range(0, 9) != 0) begin
          clock_ms += $urandom_range(0, 150);
          now = clock_ms;
        end
      end else if (r < 96) begin
        code = ReqQuery;
        if ($urandom_range(0, 9) != 0) now = clock_ms + $urandom_range(0, 60);
      end else begin
        code = ReqW'($urandom_range(ReqUnusedFirst, ReqUnusedLast));
      end
      send_req(make_req(code, s, dl, now));
    end
  endtask

  // arm every slot in shuffled order, then fire them all in one dispatch
  task automatic test_full_burst(bit calm);
    logic [SlotW-1:0] order [NumSlots];
    logic [SlotW-1:0] tmp;
    int unsigned      k;
    idle_en = !calm;
    for (int i = 0; i < NumSlots; i++) order[i] = SlotW'(i);
    for (int i = NumSlots - 1; i > 0; i--) begin
      k        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    foreach (order[i])
      send_req(make_req(ReqAdd, order[i], clock_ms + $urandom_range(0, 60), $urandom));
    clock_ms += 60;
    send_req(make_req(ReqDispatch, SlotW'($urandom), $urandom, clock_ms));
  endtask

  // test sequence
  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    rst_ni     <= 1'b0;
    idle_en     = 1'b1;
    clock_ms    = '0;
    foreach (armed[i]) armed[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_ordering();
    test_wrap_dispatch();
    clock_ms = $urandom;
    test_random_traffic(200);
    clock_ms = 32'hFFFF_FF00;
    test_full_burst(1'b1);
    test_full_burst(1'b0);
    test_full_burst(1'b0);
    in_valid_i <= 1'b0;

    // drain outstanding answers, then watch for stray results
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d requests, checked %0d results (%0d fired timers, %0d already set)",
             sent_count, result_count, fired_count, already_count);
    $display("covered empty list, ties, re-arming, wrap-around, full-list bursts");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
